// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the limiter RTL.
// Needs nothing else; included by files that check properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define LPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpl check failed");

// Implication checked in the next cycle.
`define LPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpl check failed");

`endif

// ===== hdl/lpl_pkg.sv =====
// Package for the lookahead peak limiter: widths, codes, sequencer states, helpers.
// No dependencies.
`timescale 1ns / 1ps
package lpl_pkg;
	localparam int LPL_SAMPLE_BITS = 24;
	localparam int LPL_FRAC        = LPL_SAMPLE_BITS - 1;
	localparam int LPL_MAX_DELAY   = 512;
	localparam int LPL_REG_BITS    = 24;
	localparam int LPL_LEN_BITS    = 9;
	localparam int LPL_PROD_BITS   = 30;

	localparam logic [LPL_REG_BITS-1:0] UNITY       = 24'd8388608;
	localparam logic [LPL_REG_BITS-1:0] LEVEL_FLOOR = 24'd8;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_THRESHOLD = 3'd0;
	localparam cfg_idx_t REG_CEILING   = 3'd1;
	localparam cfg_idx_t REG_MAKEUP    = 3'd2;
	localparam cfg_idx_t REG_RELEASE   = 3'd3;
	localparam cfg_idx_t REG_LENGTH    = 3'd4;
	localparam cfg_idx_t REG_BOOST     = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE, ST_HEAD_RD, ST_HEAD_CHK, ST_BACK_RD, ST_BACK_PK, ST_BACK_CHK,
		ST_PUSH, ST_MAXQ_RD, ST_MAXP_RD, ST_DIV_GO, ST_DIV_WAIT, ST_REL,
		ST_REL_WAIT, ST_OUT_RD, ST_LOAD, ST_SCALE, ST_MAKEUP, ST_FIN
	} lpl_state_t;

	typedef enum logic [1:0] {
		MUL_GAIN, MUL_MAKEUP, MUL_RELEASE
	} mul_op_t;

	typedef struct packed {
		logic                    go;
		mul_op_t                 op;
		logic [LPL_REG_BITS-1:0] a;
		logic [LPL_REG_BITS:0]   b;
	} mul_req_t;

	typedef struct packed {
		logic                    go;
		logic [LPL_REG_BITS-1:0] num;
		logic [LPL_REG_BITS-1:0] den;
	} div_req_t;

	function automatic logic [LPL_SAMPLE_BITS-1:0] mag(input logic signed [LPL_SAMPLE_BITS-1:0] s);
		mag = s[LPL_SAMPLE_BITS-1] ? LPL_SAMPLE_BITS'(-s) : LPL_SAMPLE_BITS'(s);
	endfunction

	function automatic logic [LPL_SAMPLE_BITS-1:0] peak_of(
		input logic signed [LPL_SAMPLE_BITS-1:0] l,
		input logic signed [LPL_SAMPLE_BITS-1:0] r);
		logic [LPL_SAMPLE_BITS-1:0] ml, mr;
		ml = mag(l);
		mr = mag(r);
		peak_of = (ml > mr) ? ml : mr;
	endfunction

	function automatic logic [LPL_REG_BITS-1:0] level_of(input logic [LPL_REG_BITS-1:0] v);
		if (v < LEVEL_FLOOR)
			level_of = LEVEL_FLOOR;
		else if (v > UNITY)
			level_of = UNITY;
		else
			level_of = v;
	endfunction
endpackage

// ===== hdl/lpl_if.sv =====
// Valid/ready channel interfaces for limiter input and output words.
// Depends on lpl_pkg.
`timescale 1ns / 1ps
interface lpl_in_if import lpl_pkg::*; ();
	logic                              valid;
	logic                              ready;
	logic signed [LPL_SAMPLE_BITS-1:0] left_in;
	logic signed [LPL_SAMPLE_BITS-1:0] right_in;
	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface lpl_out_if import lpl_pkg::*; ();
	logic                              valid;
	logic                              ready;
	logic signed [LPL_SAMPLE_BITS-1:0] left_out;
	logic signed [LPL_SAMPLE_BITS-1:0] right_out;
	logic [LPL_REG_BITS-1:0]           gain_now;
	modport source (output valid, left_out, right_out, gain_now, input ready);
	modport sink (input valid, left_out, right_out, gain_now, output ready);
endinterface

// ===== hdl/lookahead_peak_limiter_unit.sv =====
// Lookahead peak limiter, one stereo word at a time under a sequencer.
// A word is taken only in idle, then: head read and check; read, peak and check per
// back entry dropped; push; window max read; a 23-step divide if the peak tops the level;
// release; delayed read; scale and makeup per channel. A stalled sink holds the sequencer.
// Reset (arst_n, async, low): registers to defaults, rings and queue empty, gain unity.
// A length write empties the rings and queue at once through the fill count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lookahead_peak_limiter_unit import lpl_pkg::*; #(
	parameter int MAX_DELAY = LPL_MAX_DELAY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	lpl_in_if.sink                  frame_in,
	lpl_out_if.source               frame_out,
	input  logic                    cfg_we,
	input  cfg_idx_t                cfg_idx,
	input  logic [LPL_REG_BITS-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_DELAY);
	localparam int CW = $clog2(MAX_DELAY + 1);
	localparam int SB = LPL_SAMPLE_BITS;

	lpl_state_t state_q, state_d;

	logic [LPL_REG_BITS-1:0] thr_q, ceil_q, makeup_q, rel_q, env_q, target_q, peak_q, gain_q;
	logic [LPL_LEN_BITS-1:0] len_q;
	logic                    boost_q, ch_q, out_valid_q;
	logic [AW-1:0]           head_q, slot_q, wslot_q, rd_q;
	logic [CW-1:0]           count_q, fill_q, size;
	logic signed [SB-1:0]    l_q, r_q, lo_q, ro_q, lh_q;

	logic [LPL_REG_BITS-1:0] thr_lv, ceil_lv, level, wmax, back_pk;
	logic [AW-1:0]           q_raddr, r_raddr, q_waddr, back_idx, head_inc, rd_next;
	logic [AW-1:0]           q_rdata;
	logic [2*SB-1:0]         r_rdata;
	logic                    r_we, q_we, hand_off;
	mul_req_t                mreq;
	div_req_t                dreq;
	logic [LPL_PROD_BITS-1:0] mres;
	logic                    div_done;
	logic [LPL_REG_BITS-1:0] div_quot;
	logic signed [SB-1:0]    cur, fin;
	logic [LPL_REG_BITS-1:0] lim, mc;

	function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
		wrap = (v >= (CW+1)'(MAX_DELAY)) ? AW'(v - (CW+1)'(MAX_DELAY)) : AW'(v);
	endfunction

	assign thr_lv  = level_of(thr_q);
	assign ceil_lv = level_of(ceil_q);
	assign level   = boost_q ? thr_lv : ((thr_lv < ceil_lv) ? thr_lv : ceil_lv);
	assign size    = (32'(len_q) > 32'(MAX_DELAY - 1)) ? CW'(MAX_DELAY) : CW'(len_q) + 1'b1;
	assign head_inc = wrap((CW+1)'(head_q) + (CW+1)'(1));
	assign back_idx = wrap((CW+1)'(head_q) + (CW+1)'(count_q) - (CW+1)'(1));
	assign q_waddr  = wrap((CW+1)'(head_q) + (CW+1)'(count_q));
	assign rd_next  = (CW'(slot_q) + 1'b1 == size) ? '0 : AW'(CW'(slot_q) + 1'b1);
	assign back_pk  = peak_of(r_rdata[2*SB-1:SB], r_rdata[SB-1:0]);
	assign wmax     = back_pk;
	assign hand_off = (state_q == ST_FIN) && ch_q && (!out_valid_q || frame_out.ready);

	lpl_mem #(.DEPTH(MAX_DELAY), .WIDTH(2 * SB)) u_ring (
		.clk(clk), .we(r_we), .waddr(slot_q), .wdata({l_q, r_q}),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	lpl_mem #(.DEPTH(MAX_DELAY), .WIDTH(AW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(slot_q),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	lpl_mul u_mul (.clk(clk), .req(mreq), .res(mres));

	lpl_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quot(div_quot));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (frame_in.valid) state_d = ST_HEAD_RD;
			ST_HEAD_RD:  state_d = ST_HEAD_CHK;
			ST_HEAD_CHK: state_d = ST_BACK_RD;
			ST_BACK_RD:  state_d = (count_q == '0) ? ST_PUSH : ST_BACK_PK;
			ST_BACK_PK:  state_d = ST_BACK_CHK;
			ST_BACK_CHK: state_d = (back_pk > peak_q) ? ST_PUSH : ST_BACK_RD;
			ST_PUSH:     state_d = ST_MAXQ_RD;
			ST_MAXQ_RD:  state_d = ST_MAXP_RD;
			ST_MAXP_RD:  state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = (wmax > level) ? ST_DIV_WAIT : ST_REL;
			ST_DIV_WAIT: if (div_done) state_d = ST_REL;
			ST_REL:      state_d = (target_q < env_q) ? ST_OUT_RD : ST_REL_WAIT;
			ST_REL_WAIT: state_d = ST_OUT_RD;
			ST_OUT_RD:   state_d = ST_LOAD;
			ST_LOAD:     state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_MAKEUP;
			ST_MAKEUP:   state_d = ST_FIN;
			ST_FIN: begin
				if (!ch_q)
					state_d = ST_SCALE;
				else if (!out_valid_q || frame_out.ready)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_raddr  = head_q;
		r_raddr  = q_rdata;
		r_we     = 1'b0;
		q_we     = 1'b0;
		mreq     = '{go: 1'b0, op: MUL_GAIN, a: '0, b: '0};
		dreq     = '{go: 1'b0, num: level, den: wmax};
		cur      = ch_q ? r_q : l_q;
		case (state_q)
			ST_BACK_RD: q_raddr = back_idx;
			ST_PUSH: begin
				r_we = 1'b1;
				q_we = (count_q < CW'(MAX_DELAY));
			end
			ST_DIV_GO:  dreq.go = (wmax > level);
			ST_REL: begin
				mreq.go = !(target_q < env_q);
				mreq.op = MUL_RELEASE;
				mreq.a  = target_q - env_q;
				mreq.b  = (25'd1 << LPL_REG_BITS) - {1'b0, rel_q};
			end
			ST_OUT_RD:  r_raddr = rd_next;
			ST_SCALE: begin
				mreq.go = 1'b1;
				mreq.op = MUL_GAIN;
				mreq.a  = mag(cur);
				mreq.b  = {1'b0, env_q};
			end
			ST_MAKEUP: begin
				mreq.go = boost_q;
				mreq.op = MUL_MAKEUP;
				mreq.a  = mres[LPL_REG_BITS-1:0];
				mreq.b  = {1'b0, makeup_q};
			end
			default: ;
		endcase
	end

	// brickwall clamp of the scaled magnitude
	always_comb begin
		lim = cur[SB-1] ? ceil_lv : ((ceil_lv < UNITY) ? ceil_lv : UNITY - 1'b1);
		mc  = (mres > LPL_PROD_BITS'(lim)) ? lim : mres[LPL_REG_BITS-1:0];
		fin = cur[SB-1] ? SB'(-mc) : SB'(mc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= 24'd8388608;
			ceil_q      <= 24'd8104390;
			makeup_q    <= 24'd524288;
			rel_q       <= 24'd16776691;
			len_q       <= 9'd240;
			boost_q     <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			wslot_q     <= '0;
			env_q       <= UNITY;
			gain_q      <= UNITY;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (hand_off)
				out_valid_q <= 1'b1;
			else if (frame_out.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_THRESHOLD: thr_q    <= cfg_data;
					REG_CEILING:   ceil_q   <= cfg_data;
					REG_MAKEUP:    makeup_q <= cfg_data;
					REG_RELEASE:   rel_q    <= cfg_data;
					REG_LENGTH: begin
						len_q   <= cfg_data[LPL_LEN_BITS-1:0];
						head_q  <= '0;
						count_q <= '0;
						fill_q  <= '0;
						wslot_q <= '0;
					end
					REG_BOOST:     boost_q  <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_HEAD_CHK: if (count_q != '0 && q_rdata == slot_q) begin
					head_q  <= head_inc;
					count_q <= count_q - 1'b1;
				end
				ST_BACK_CHK: if (!(back_pk > peak_q)) count_q <= count_q - 1'b1;
				ST_PUSH: begin
					if (count_q < CW'(MAX_DELAY)) count_q <= count_q + 1'b1;
					if (fill_q < size) fill_q <= fill_q + 1'b1;
				end
				ST_REL:      if (target_q < env_q) env_q <= target_q;
				ST_REL_WAIT: env_q <= env_q + mres[LPL_REG_BITS-1:0];
				ST_OUT_RD:   wslot_q <= rd_next;
				ST_FIN: begin
					if (!ch_q)
						ch_q <= 1'b1;
					else if (hand_off) begin
						ch_q   <= 1'b0;
						gain_q <= env_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				l_q    <= frame_in.left_in;
				r_q    <= frame_in.right_in;
				peak_q <= peak_of(frame_in.left_in, frame_in.right_in);
				slot_q <= wslot_q;
			end
			ST_DIV_GO:   target_q <= UNITY;
			ST_DIV_WAIT: target_q <= div_quot;
			ST_OUT_RD:   rd_q <= rd_next;
			ST_LOAD: begin
				if (CW'(rd_q) < fill_q) begin
					l_q <= r_rdata[2*SB-1:SB];
					r_q <= r_rdata[SB-1:0];
				end else begin
					l_q <= '0;
					r_q <= '0;
				end
			end
			ST_FIN: begin
				if (!ch_q)
					lh_q <= fin;
				else if (hand_off) begin
					lo_q <= lh_q;
					ro_q <= fin;
				end
			end
			default: ;
		endcase
	end

	assign frame_in.ready      = (state_q == ST_IDLE);
	assign frame_out.valid     = out_valid_q;
	assign frame_out.left_out  = lo_q;
	assign frame_out.right_out = ro_q;
	assign frame_out.gain_now  = gain_q;

	`LPL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, frame_in.valid && frame_in.ready, !frame_in.ready)
	`LPL_ASSERT_NOW(a_queue_in_window, clk, arst_n, 1'b1, count_q <= fill_q && fill_q <= size)
	`LPL_ASSERT_NOW(a_gain_unity, clk, arst_n, frame_out.valid, frame_out.gain_now <= UNITY)
endmodule

// ===== hdl/lpl_mem.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on lpl_pkg for its parameter defaults.
`timescale 1ns / 1ps
module lpl_mem import lpl_pkg::*; #(
	parameter int DEPTH = LPL_MAX_DELAY,
	parameter int WIDTH = 2 * LPL_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/lpl_div.sv =====
// Restoring divider, one quotient bit a cycle: floor(num * 2^FRAC / den), num < den.
// Depends on lpl_pkg.
`timescale 1ns / 1ps
module lpl_div import lpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  div_req_t                req,
	output logic                    done,
	output logic [LPL_REG_BITS-1:0] quot
);
	localparam int NW = $clog2(LPL_FRAC + 1);

	logic [LPL_REG_BITS-1:0] rem_q, den_q, quo_q;
	logic [NW-1:0]           cnt_q;
	logic                    busy_q, done_q;
	logic [LPL_REG_BITS:0]   trial;

	assign trial = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(LPL_FRAC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= LPL_REG_BITS'(trial - {1'b0, den_q});
				quo_q <= {quo_q[LPL_REG_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[LPL_REG_BITS-1:0];
				quo_q <= {quo_q[LPL_REG_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

// ===== hdl/lpl_mul.sv =====
// Shared multiplier with rounding shift; result registered, held until the next issue.
// Depends on lpl_pkg.
`timescale 1ns / 1ps
module lpl_mul import lpl_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic [LPL_PROD_BITS-1:0] res
);
	localparam int PW = 2 * LPL_REG_BITS + 2;
	localparam int MK = 19;

	logic [PW-1:0] prod, sum, shd;

	always_comb begin
		prod = PW'(req.a) * PW'(req.b);
		case (req.op)
			MUL_GAIN: begin
				sum = prod + (PW'(1) << (LPL_FRAC - 1));
				shd = sum >> LPL_FRAC;
			end
			MUL_MAKEUP: begin
				sum = prod + (PW'(1) << (MK - 1));
				shd = sum >> MK;
			end
			MUL_RELEASE: begin
				sum = prod + ((PW'(1) << LPL_REG_BITS) - PW'(1));
				shd = sum >> LPL_REG_BITS;
			end
			default: begin
				sum = prod;
				shd = prod;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.go)
			res <= shd[LPL_PROD_BITS-1:0];
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the lookahead peak limiter: valid/ready driver, monitor and
// a word-level software predictor of the ring, the peak queue, the envelope and clamp.
// Depends on lpl_pkg, lpl_if.sv and lookahead_peak_limiter_unit.
`timescale 1ns / 1ps
module testbench;
	import lpl_pkg::*;

	localparam cfg_idx_t REG_SPARE = 3'd7;
	localparam int RING_DEPTH = 512;
	localparam int WORD_CAP = 4096;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic signed [LPL_SAMPLE_BITS-1:0] left;
		logic signed [LPL_SAMPLE_BITS-1:0] right;
	} stereo_word_t;

	typedef struct {
		logic signed [LPL_SAMPLE_BITS-1:0] left;
		logic signed [LPL_SAMPLE_BITS-1:0] right;
		logic [LPL_REG_BITS-1:0]           gain;
	} limited_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_idx = REG_THRESHOLD;
	logic [LPL_REG_BITS-1:0] cfg_data = '0;

	lpl_in_if frame_in ();
	lpl_out_if frame_out ();

	lookahead_peak_limiter_unit u_top (
		.clk(clk), .arst_n(arst_n), .frame_in(frame_in.sink), .frame_out(frame_out.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stereo_word_t  pending_words[WORD_CAP];
	limited_word_t expected_words[WORD_CAP];
	int  pend_wr = 0, pend_rd = 0;
	int  exp_wr = 0, exp_rd = 0;
	bit  in_fire = 1'b0;
	int  src_idle_pct = 0;
	int  snk_stall_pct = 0;
	int  mismatches = 0;
	longint cycles = 0;

	// limiter state mirror
	longint unsigned thr_reg = 8388608, ceil_reg = 8104390, makeup_reg = 524288;
	longint unsigned release_reg = 16776691, boost_reg = 0;
	int len_reg = 240;
	longint left_hist[RING_DEPTH], right_hist[RING_DEPTH];
	longint unsigned peak_hist[RING_DEPTH];
	int peak_idx_q[RING_DEPTH];
	int q_head = 0, q_count = 0, wr_slot = 0;
	longint unsigned envelope = 8388608;

	function automatic void add_pending(input stereo_word_t w);
		pending_words[pend_wr % WORD_CAP] = w;
		pend_wr++;
	endfunction

	function automatic void add_expected(input limited_word_t w);
		expected_words[exp_wr % WORD_CAP] = w;
		exp_wr++;
	endfunction

	function automatic longint unsigned clip_level(input longint unsigned v);
		if (v < LEVEL_FLOOR) return LEVEL_FLOOR;
		if (v > UNITY) return UNITY;
		return v;
	endfunction

	function automatic longint abs_val(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_mul(input longint a, input longint unsigned b, input int sh);
		longint unsigned m;
		m = (longint'(abs_val(a)) * b + (64'd1 << (sh - 1))) >> sh;
		return a < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [LPL_SAMPLE_BITS-1:0] clamp_out(input longint v,
			input longint unsigned c);
		if (v > longint'(c)) v = c;
		if (v < -longint'(c)) v = -longint'(c);
		if (v > longint'(UNITY) - 1) v = longint'(UNITY) - 1;
		return v[LPL_SAMPLE_BITS-1:0];
	endfunction

	function automatic void clear_history();
		for (int i = 0; i < RING_DEPTH; i++) begin
			left_hist[i] = 0;
			right_hist[i] = 0;
			peak_hist[i] = 0;
		end
		q_head = 0;
		q_count = 0;
		wr_slot = 0;
	endfunction

	function automatic void limit_word(input stereo_word_t w);
		longint l, r, pl, pr;
		longint unsigned thr, cl, lvl, pk, wmax, target, d, k;
		int ring_len, slot, rd, back;
		limited_word_t res;
		l = w.left;
		r = w.right;
		thr = clip_level(thr_reg);
		cl = clip_level(ceil_reg);
		lvl = boost_reg ? thr : (thr < cl ? thr : cl);
		pk = abs_val(l) > abs_val(r) ? abs_val(l) : abs_val(r);
		ring_len = len_reg + 1;
		slot = wr_slot;
		if (q_count > 0 && peak_idx_q[q_head] == slot) begin
			q_head = (q_head + 1) % RING_DEPTH;
			q_count--;
		end
		while (q_count > 0) begin
			back = (q_head + q_count - 1) % RING_DEPTH;
			if (peak_hist[peak_idx_q[back]] > pk) break;
			q_count--;
		end
		peak_hist[slot] = pk;
		left_hist[slot] = l;
		right_hist[slot] = r;
		if (q_count < RING_DEPTH) begin
			peak_idx_q[(q_head + q_count) % RING_DEPTH] = slot;
			q_count++;
		end
		wmax = peak_hist[peak_idx_q[q_head]];
		target = (wmax > lvl) ? (lvl << LPL_FRAC) / wmax : UNITY;
		if (target < envelope) begin
			envelope = target;
		end else begin
			d = target - envelope;
			k = (64'd1 << 24) - release_reg;
			envelope += (d * k + (64'd1 << 24) - 1) >> 24;
		end
		if (envelope > UNITY) envelope = UNITY;
		rd = (slot + 1) % ring_len;
		pl = round_mul(left_hist[rd], envelope, LPL_FRAC);
		pr = round_mul(right_hist[rd], envelope, LPL_FRAC);
		if (boost_reg) begin
			pl = round_mul(pl, makeup_reg, 19);
			pr = round_mul(pr, makeup_reg, 19);
		end
		wr_slot = rd;
		res.left = clamp_out(pl, cl);
		res.right = clamp_out(pr, cl);
		res.gain = envelope[LPL_REG_BITS-1:0];
		add_expected(res);
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [LPL_REG_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_THRESHOLD: thr_reg = val;
			REG_CEILING:   ceil_reg = val;
			REG_MAKEUP:    makeup_reg = val;
			REG_RELEASE:   release_reg = val;
			REG_LENGTH: begin
				len_reg = val[LPL_LEN_BITS-1:0];
				clear_history();
			end
			REG_BOOST:     boost_reg = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pend_rd != pend_wr || exp_rd != exp_wr)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [LPL_SAMPLE_BITS-1:0] pick_sample();
		int kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: return 24'($urandom);
			4, 5: return $urandom_range(0, 1)
				? 24'(32'sd8388607 - int'($urandom_range(0, 600000)))
				: 24'(-32'sd8388608 + int'($urandom_range(0, 600000)));
			6: return 24'(int'($urandom_range(0, 2000)) - 1000);
			7: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed(24'($urandom)) >>> $urandom_range(1, 8));
		endcase
	endfunction

	task automatic queue_random(input int n);
		stereo_word_t w;
		for (int i = 0; i < n; i++) begin
			w.left = pick_sample();
			w.right = ($urandom_range(0, 3) == 0) ? w.left : pick_sample();
			add_pending(w);
		end
	endtask

	task automatic queue_pair(input logic [23:0] l, input logic [23:0] r);
		stereo_word_t w;
		w.left = l;
		w.right = r;
		add_pending(w);
	endtask

	// driver
	always @(posedge clk)
		if (arst_n && frame_in.valid && frame_in.ready) begin
			limit_word(pending_words[pend_rd % WORD_CAP]);
			pend_rd++;
			in_fire = 1'b1;
		end

	always @(negedge clk) begin
		if (arst_n && pend_rd != pend_wr &&
				((frame_in.valid && !in_fire) || $urandom_range(0, 99) >= src_idle_pct)) begin
			frame_in.valid <= 1'b1;
			frame_in.left_in <= pending_words[pend_rd % WORD_CAP].left;
			frame_in.right_in <= pending_words[pend_rd % WORD_CAP].right;
		end else begin
			frame_in.valid <= 1'b0;
		end
		in_fire = 1'b0;
		frame_out.ready <= arst_n && ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		limited_word_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && frame_out.valid && frame_out.ready) begin
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: l=%0d r=%0d g=%0d", frame_out.left_out,
						frame_out.right_out, frame_out.gain_now);
			end else begin
				e = expected_words[exp_rd % WORD_CAP];
				exp_rd++;
				if (frame_out.left_out !== e.left || frame_out.right_out !== e.right ||
						frame_out.gain_now !== e.gain) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp l=%0d r=%0d g=%0d, got l=%0d r=%0d g=%0d",
							e.left, e.right, e.gain, frame_out.left_out,
							frame_out.right_out, frame_out.gain_now);
				end
			end
		end
	end

	initial begin
		frame_in.valid = 1'b0;
		frame_in.left_in = '0;
		frame_in.right_in = '0;
		frame_out.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, directed extremes
		queue_pair(24'h7FFFFF, 24'h800000);
		queue_pair(24'h800000, 24'h7FFFFF);
		queue_pair(24'h000000, 24'h000000);
		queue_pair(24'hFFFFFF, 24'h000001);
		queue_pair(24'h7FFFFF, 24'h7FFFFF);
		queue_pair(24'h800000, 24'h800000);
		queue_pair(24'h400000, 24'hC00000);
		queue_pair(24'h7BA9C6, 24'h000000);
		queue_pair(24'h000000, 24'h7BA9C7);
		queue_pair(24'h555555, 24'hAAAAAA);
		settle();

		// undelayed path, level floor, unity ceiling, instant release
		write_reg(REG_LENGTH, 24'd0);
		write_reg(REG_THRESHOLD, 24'd0);
		write_reg(REG_CEILING, UNITY);
		write_reg(REG_RELEASE, 24'd0);
		write_reg(REG_SPARE, 24'hFFFFFF);
		queue_pair(24'h7FFFFF, 24'h800000);
		queue_pair(24'h000007, 24'hFFFFF8);
		queue_pair(24'h000000, 24'h000000);
		queue_pair(24'h7FFFFF, 24'h7FFFFF);
		queue_random(200);
		src_idle_pct = 60;
		settle();

		// longest ring, boost with makeup set to UNITY, slowest release
		src_idle_pct = 0;
		snk_stall_pct = 60;
		write_reg(REG_LENGTH, 24'h1FF);
		write_reg(REG_BOOST, 24'd1);
		write_reg(REG_MAKEUP, UNITY);
		write_reg(REG_THRESHOLD, 24'd4194304);
		write_reg(REG_CEILING, UNITY);
		write_reg(REG_RELEASE, 24'hFFFFFF);
		queue_random(650);
		settle();

		// short ring, zero makeup and zero ceiling
		src_idle_pct = 33;
		snk_stall_pct = 33;
		write_reg(REG_LENGTH, 24'd7);
		write_reg(REG_MAKEUP, 24'd0);
		write_reg(REG_THRESHOLD, 24'd1000000);
		write_reg(REG_CEILING, 24'd0);
		write_reg(REG_RELEASE, 24'd12000000);
		queue_random(250);
		settle();

		// random settings
		for (int p = 0; p < 5; p++) begin
			src_idle_pct = (p % 2) ? 60 : 0;
			snk_stall_pct = (p % 3 == 0) ? 0 : 33;
			write_reg(REG_LENGTH, 24'($urandom_range(0, 40)));
			write_reg(REG_BOOST, 24'($urandom_range(0, 1)));
			write_reg(REG_THRESHOLD, 24'($urandom_range(0, 8388608)));
			write_reg(REG_CEILING, 24'($urandom_range(0, 8388608)));
			write_reg(REG_MAKEUP, 24'($urandom_range(0, 8388608)));
			write_reg(REG_RELEASE, 24'($urandom_range(0, 16777215)));
			queue_random(150);
			settle();
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
